// ===== design/psg_four_channel_sound_generator_defines.svh =====
// assertion helpers for the checker file psg_chk.sv
`ifndef PSG_FOUR_CHANNEL_SOUND_GENERATOR_DEFINES_SVH
`define PSG_FOUR_CHANNEL_SOUND_GENERATOR_DEFINES_SVH

// consequent checked in the same cycle
`define PSG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/psg_pkg.sv =====
package psg_pkg;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_WRITE  = 10'b00_0000_0010,
    ST_DEC    = 10'b00_0000_0100,
    ST_LOOP   = 10'b00_0000_1000,
    ST_SIGN   = 10'b00_0001_0000,
    ST_LEVEL  = 10'b00_0010_0000,
    ST_MUL    = 10'b00_0100_0000,
    ST_ACC    = 10'b00_1000_0000,
    ST_DIRECT = 10'b01_0000_0000,
    ST_RESULT = 10'b10_0000_0000
  } psg_state_e;

  typedef struct packed {
    logic       capture;
    logic       wr;
    logic       dec;
    logic       step;
    logic       sign;
    logic       level;
    logic       mul;
    logic       acc;
    logic       direct;
    logic       load;
    logic [1:0] ch;
  } psg_cmd_t;

  typedef struct packed {
    logic powered;
    logic runs;
    logic sweep_kill;
    logic timer_le0;
    logic out_free;
  } psg_stat_t;

  localparam logic [2:0] KIND_SWEEP  = 3'd0;
  localparam logic [2:0] KIND_DUTY   = 3'd1;
  localparam logic [2:0] KIND_FREQ   = 3'd2;
  localparam logic [2:0] KIND_MASTER = 3'd3;
  localparam logic [2:0] KIND_WAVE   = 3'd4;

  localparam logic [1:0] CFG_MIX_LEVELS  = 2'd0;
  localparam logic [1:0] CFG_MIX_CONTROL = 2'd1;
  localparam logic [1:0] CFG_BIAS        = 2'd2;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 32;
  localparam int TIMER_W    = 24;

  localparam logic [9:0]  BIAS_RESET = 10'd512;
  localparam logic [8:0]  ENV_STEP   = 9'd448;
  localparam logic [11:0] RECIP7     = 12'd2341;

  function automatic logic [TIMER_W-1:0] noise_period(input logic [15:0] f);
    logic [6:0] d;
    d = (f[2:0] == 3'd0) ? 7'd8 : {f[2:0], 4'd0};
    return {17'd0, d} << f[7:4];
  endfunction

  // 128 * e / 15
  function automatic logic [7:0] sq_level(input logic [3:0] e);
    logic [7:0] r;
    case (e)
      4'd0:  r = 8'd0;
      4'd1:  r = 8'd8;
      4'd2:  r = 8'd17;
      4'd3:  r = 8'd25;
      4'd4:  r = 8'd34;
      4'd5:  r = 8'd42;
      4'd6:  r = 8'd51;
      4'd7:  r = 8'd59;
      4'd8:  r = 8'd68;
      4'd9:  r = 8'd76;
      4'd10: r = 8'd85;
      4'd11: r = 8'd93;
      4'd12: r = 8'd102;
      4'd13: r = 8'd110;
      4'd14: r = 8'd119;
      default: r = 8'd128;
    endcase
    return r;
  endfunction

  // v * 256 / 15
  function automatic logic [8:0] wave_level(input logic [3:0] v);
    logic [8:0] r;
    case (v)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd17;
      4'd2:  r = 9'd34;
      4'd3:  r = 9'd51;
      4'd4:  r = 9'd68;
      4'd5:  r = 9'd85;
      4'd6:  r = 9'd102;
      4'd7:  r = 9'd119;
      4'd8:  r = 9'd136;
      4'd9:  r = 9'd153;
      4'd10: r = 9'd170;
      4'd11: r = 9'd187;
      4'd12: r = 9'd204;
      4'd13: r = 9'd221;
      4'd14: r = 9'd238;
      default: r = 9'd256;
    endcase
    return r;
  endfunction

endpackage

// ===== design/psg_four_channel_sound_generator.sv =====
// channel | kind           | timer step per tick | level source
// 0       | square + sweep | 4                   | envelope 0
// 1       | square         | 4                   | envelope 1
// 2       | 4-bit wave     | 64                  | wave memory, shift code
// 3       | noise lfsr     | 16                  | envelope 2
//
// a write request passes through ST_WRITE; a tick while powered off goes to ST_RESULT
// a powered tick: ST_DEC per channel; ST_LOOP (repeats per timer reload), ST_SIGN,
// ST_LEVEL per running channel; ST_MUL, ST_ACC per channel; then ST_DIRECT, ST_RESULT
// wave memory valid bits clear at reset, so no clearing pass is needed
// a finished sample waits in the output register; the next request is taken meanwhile
module psg_four_channel_sound_generator import psg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // channel, wave_index, write_mask, write_data, direct_a, direct_b, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode, reg_kind
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // left_sample, right_sample, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i
);

  psg_cmd_t    cmd;
  psg_stat_t   stat;
  logic [14:0] left_sample, right_sample;

  psg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .tick_i    (!s_axis_tuser[0]),
    .stat_i    (stat),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  psg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .reg_kind_i     (s_axis_tuser[3:1]),
    .channel_i      (s_axis_tdata[1:0]),
    .wave_index_i   (s_axis_tdata[5:2]),
    .write_mask_i   (s_axis_tdata[21:6]),
    .write_data_i   (s_axis_tdata[37:22]),
    .direct_a_i     (s_axis_tdata[45:38]),
    .direct_b_i     (s_axis_tdata[53:46]),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .left_sample_o  (left_sample),
    .right_sample_o (right_sample)
  );

  assign m_axis_tdata = {2'd0, right_sample, left_sample};

endmodule

// ===== design/psg_ram.sv =====
module psg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/psg_ctrl.sv =====
module psg_ctrl import psg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  input  logic      tick_i,
  input  psg_stat_t stat_i,
  output logic      s_ready_o,
  output psg_cmd_t  cmd_o
);

  psg_state_e state_q, state_d;
  logic [1:0] ch_q, ch_d;

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    cmd_o     = '0;
    cmd_o.ch  = ch_q;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          ch_d = 2'd0;
          if (!tick_i) begin
            state_d = ST_WRITE;
          end else if (stat_i.powered) begin
            state_d = ST_DEC;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_DEC: begin
        if (stat_i.runs && !stat_i.sweep_kill) begin
          cmd_o.dec = 1'b1;
          state_d   = ST_LOOP;
        end else begin
          cmd_o.dec = stat_i.runs;
          if (ch_q == 2'd3) begin
            state_d = ST_MUL;
            ch_d    = 2'd0;
          end else begin
            ch_d = ch_q + 2'd1;
          end
        end
      end
      ST_LOOP: begin
        if (stat_i.timer_le0) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        cmd_o.sign = 1'b1;
        state_d    = ST_LEVEL;
      end
      ST_LEVEL: begin
        cmd_o.level = 1'b1;
        if (ch_q == 2'd3) begin
          state_d = ST_MUL;
          ch_d    = 2'd0;
        end else begin
          state_d = ST_DEC;
          ch_d    = ch_q + 2'd1;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (ch_q == 2'd3) begin
          state_d = ST_DIRECT;
        end else begin
          state_d = ST_MUL;
          ch_d    = ch_q + 2'd1;
        end
      end
      ST_DIRECT: begin
        cmd_o.direct = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

endmodule

// ===== design/psg_dp.sv =====
module psg_dp import psg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psg_cmd_t          cmd_i,
  output psg_stat_t         stat_o,
  input  logic [2:0]        reg_kind_i,
  input  logic [1:0]        channel_i,
  input  logic [3:0]        wave_index_i,
  input  logic [15:0]       write_mask_i,
  input  logic [15:0]       write_data_i,
  input  logic signed [7:0] direct_a_i,
  input  logic signed [7:0] direct_b_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [14:0]       left_sample_o,
  output logic [14:0]       right_sample_o
);

  // captured request
  logic [2:0]        kind_q;
  logic [1:0]        wch_q;
  logic [3:0]        widx_q;
  logic [15:0]       wmask_q, wdata_q;
  logic signed [7:0] da_q, db_q;

  logic [15:0] mix_levels_q, mix_control_q;
  logic [9:0]  bias_q;

  logic [7:0]  sweep_q [2];
  logic [7:0]  sweep_d [2];
  logic [15:0] duty_q [4];
  logic [15:0] duty_d [4];
  logic [15:0] freq_q [4];
  logic [15:0] freq_d [4];
  logic signed [TIMER_W-1:0] timer_q [4];
  logic signed [TIMER_W-1:0] timer_d [4];
  logic [3:0]        lvl_q [3];
  logic [3:0]        lvl_d [3];
  logic signed [3:0] ecnt_q [3];
  logic signed [3:0] ecnt_d [3];
  logic signed [9:0] data_q [4];
  logic signed [9:0] data_d [4];
  logic        on_q, on_d;
  logic [3:0]  active_q, active_d;
  logic [8:0]  frame_q, frame_d;
  logic signed [3:0] scount_q, scount_d;
  logic [5:0]  pos_q, pos_d;
  logic [15:0] noise_q, noise_d;
  logic [31:0] wvalid_q, wvalid_d;
  logic        sign_q, sign_d;
  logic        rvalid_q, rvalid_d;
  logic signed [13:0] prod_l_q, prod_l_d, prod_r_q, prod_r_d;
  logic signed [13:0] acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic        out_valid_q, out_valid_d;
  logic [14:0] left_q, left_d, right_q, right_d;

  logic [1:0]  ch;
  logic [1:0]  ek;
  logic [11:0] per;
  logic [TIMER_W-1:0] add_amt;
  logic signed [TIMER_W-1:0] tcur;
  logic        le0;
  logic        runs;
  logic        sw_cond, sw_due, sw_kill;
  logic signed [3:0] scnt_n;
  logic [10:0] f0, d0;
  logic [11:0] fn;
  logic [14:0] duty_prod;
  logic [11:0] duty_val;
  logic [15:0] lmask, len_full, len_n;
  logic signed [3:0] ecnt_n;
  logic [15:0] ereg;
  logic        rd_bank;
  logic [4:0]  raddr, waddr;
  logic [7:0]  rdata, byte_v;
  logic [3:0]  nib, nib_s;
  logic [5:0]  nib3;
  logic [7:0]  mag8;
  logic signed [9:0] ds;
  logic [13:0] mag_l, mag_r;
  logic [24:0] q_l, q_r;
  logic signed [13:0] a_ext, b_ext, a_add, b_add;
  logic signed [13:0] sum_l, sum_r;
  logic [9:0]  c_l, c_r;
  logic [15:0] wm, newf, lfsr_n, tap;
  logic        ram_we;

  assign ch = cmd_i.ch;
  assign ek = (ch == 2'd3) ? 2'd2 : ch;

  function automatic logic [9:0] clamp10(input logic signed [13:0] s);
    logic [9:0] r;
    if (s < 0) begin
      r = 10'd0;
    end else if (s > 14'sd1023) begin
      r = 10'd1023;
    end else begin
      r = s[9:0];
    end
    return r;
  endfunction

  always_comb begin
    per     = 12'h800 - {1'b0, freq_q[ch][10:0]};
    add_amt = (ch == 2'd3) ? noise_period(freq_q[3]) : {12'd0, per};
    tcur    = timer_q[ch];
    le0     = tcur[TIMER_W-1] || (tcur == '0);
    case (ch)
      2'd2:    runs = active_q[2] && sweep_q[1][7];
      default: runs = active_q[ch];
    endcase

    // channel 0 frequency sweep
    sw_cond = (frame_q[7:0] == 8'd128) && (sweep_q[0][6:4] != 3'd0);
    scnt_n  = scount_q - 4'sd1;
    sw_due  = sw_cond && (scnt_n[3] || (scnt_n == 4'sd0));
    f0      = freq_q[0][10:0];
    d0      = f0 >> sweep_q[0][2:0];
    fn      = sweep_q[0][3] ? ({1'b0, f0} - {1'b0, d0}) : ({1'b0, f0} + {1'b0, d0});
    sw_kill = (ch == 2'd0) && sw_due && fn[11];

    case (duty_q[ch][7:6])
      2'd0:    duty_prod = {3'd0, per} * 15'd7;
      2'd1:    duty_prod = {3'd0, per} * 15'd6;
      2'd2:    duty_prod = {3'd0, per} * 15'd4;
      default: duty_prod = {3'd0, per} * 15'd2;
    endcase
    duty_val = duty_prod[14:3];

    lmask    = (ch == 2'd2) ? 16'h00FF : 16'h003F;
    len_full = duty_q[ch] & lmask;
    len_n    = len_full - 16'd1;
    ecnt_n   = ecnt_q[ek] - 4'sd1;
    ereg     = duty_q[ch];

    rd_bank = sweep_q[1][6] ^ (sweep_q[1][5] & pos_q[5]);
    raddr   = {rd_bank, pos_q[4:1]};
    waddr   = {~sweep_q[1][6], widx_q};

    byte_v = rvalid_q ? rdata : 8'd0;
    nib    = pos_q[0] ? byte_v[3:0] : byte_v[7:4];
    nib3   = {2'd0, nib} * 6'd3;
    case (duty_q[2][15:13])
      3'd0:    nib_s = 4'd0;
      3'd1:    nib_s = nib;
      3'd2:    nib_s = nib >> 1;
      3'd3:    nib_s = nib >> 2;
      default: nib_s = nib3[5:2];
    endcase
    mag8 = sq_level(lvl_q[ek]);

    case (mix_control_q[1:0])
      2'd0:    ds = data_q[ch] >>> 2;
      2'd1:    ds = data_q[ch] >>> 1;
      default: ds = data_q[ch];
    endcase

    // divide by 7, rounding toward zero
    mag_l = prod_l_q[13] ? 14'(-prod_l_q) : prod_l_q;
    mag_r = prod_r_q[13] ? 14'(-prod_r_q) : prod_r_q;
    q_l   = {11'd0, mag_l} * {13'd0, RECIP7};
    q_r   = {11'd0, mag_r} * {13'd0, RECIP7};

    a_ext = 14'(da_q);
    b_ext = 14'(db_q);
    a_add = mix_control_q[2] ? (a_ext <<< 2) : (a_ext <<< 1);
    b_add = mix_control_q[3] ? (b_ext <<< 2) : (b_ext <<< 1);

    sum_l = acc_l_q + $signed({4'd0, bias_q});
    sum_r = acc_r_q + $signed({4'd0, bias_q});
    c_l   = clamp10(sum_l);
    c_r   = clamp10(sum_r);

    tap    = freq_q[3][3] ? 16'h0060 : 16'h6000;
    lfsr_n = noise_q[0] ? (16'h8000 | ({2'b0, noise_q[14:1]} ^ tap)) : {2'b0, noise_q[14:1]};

    case (wch_q)
      2'd3:    wm = write_mask_i & 16'h0000 | (wmask_q & 16'h40FF);
      default: wm = wmask_q & 16'h47FF;
    endcase
    newf = (freq_q[wch_q] & ~wm) | (wdata_q & wm);
  end

  assign ram_we = cmd_i.wr && (kind_q == KIND_WAVE);

  psg_ram #(.WIDTH(8), .DEPTH(32)) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata_q[7:0]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    sweep_d     = sweep_q;
    duty_d      = duty_q;
    freq_d      = freq_q;
    timer_d     = timer_q;
    lvl_d       = lvl_q;
    ecnt_d      = ecnt_q;
    data_d      = data_q;
    on_d        = on_q;
    active_d    = active_q;
    frame_d     = frame_q;
    scount_d    = scount_q;
    pos_d       = pos_q;
    noise_d     = noise_q;
    wvalid_d    = wvalid_q;
    sign_d      = sign_q;
    rvalid_d    = rvalid_q;
    prod_l_d    = prod_l_q;
    prod_r_d    = prod_r_q;
    acc_l_d     = acc_l_q;
    acc_r_d     = acc_r_q;
    left_d      = left_q;
    right_d     = right_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.capture) begin
      for (int i = 0; i < 4; i++) begin
        data_d[i] = '0;
      end
      acc_l_d = '0;
      acc_r_d = '0;
    end

    if (cmd_i.wr) begin
      case (kind_q)
        KIND_SWEEP: begin
          if (on_q) begin
            if (wch_q == 2'd0) begin
              sweep_d[0] = (sweep_q[0] & 8'h80) | (wdata_q[7:0] & 8'h7F);
            end else begin
              sweep_d[wch_q[1]] = (sweep_q[wch_q[1]] & 8'h1F) | (wdata_q[7:0] & 8'hE0);
            end
          end
        end
        KIND_DUTY: begin
          if (on_q) begin
            case (wch_q)
              2'd2: duty_d[2] = (duty_q[2] & ~(wmask_q & 16'hE0FF)) |
                                (wdata_q & wmask_q & 16'hE0FF);
              2'd3: duty_d[3] = (duty_q[3] & ~(wmask_q & 16'hFF3F)) |
                                (wdata_q & wmask_q & 16'hFF3F);
              default: duty_d[wch_q] = (duty_q[wch_q] & ~wmask_q) | (wdata_q & wmask_q);
            endcase
          end
        end
        KIND_FREQ: begin
          if (on_q) begin
            freq_d[wch_q] = newf;
            if (wdata_q[15]) begin
              active_d[wch_q] = 1'b1;
              case (wch_q)
                2'd2: begin
                  pos_d      = '0;
                  timer_d[2] = $signed({12'd0, 12'h800 - {1'b0, newf[10:0]}});
                end
                2'd3: begin
                  noise_d    = newf[3] ? 16'h0040 : 16'h4000;
                  lvl_d[2]   = duty_q[3][15:12];
                  ecnt_d[2]  = $signed({1'b0, duty_q[3][10:8]});
                  timer_d[3] = $signed(noise_period(newf));
                end
                default: begin
                  if (wch_q == 2'd0) begin
                    scount_d = $signed({1'b0, sweep_q[0][6:4]});
                  end
                  lvl_d[wch_q]   = duty_q[wch_q][15:12];
                  ecnt_d[wch_q]  = $signed({1'b0, duty_q[wch_q][10:8]});
                  timer_d[wch_q] = $signed({12'd0, 12'h800 - {1'b0, newf[10:0]}});
                end
              endcase
            end
          end
        end
        KIND_MASTER: begin
          on_d = wdata_q[7];
          if (!wdata_q[7]) begin
            for (int i = 0; i < 4; i++) begin
              duty_d[i] = '0;
              freq_d[i] = '0;
            end
            sweep_d[0] = '0;
            sweep_d[1] = '0;
            active_d   = '0;
            frame_d    = '0;
          end
        end
        KIND_WAVE: begin
          wvalid_d[waddr] = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.dec) begin
      if (ch == 2'd0 && sw_cond) begin
        if (sw_due && !fn[11]) begin
          freq_d[0] = {freq_q[0][15:11], fn[10:0]};
          scount_d  = $signed({1'b0, sweep_q[0][6:4]});
        end else begin
          scount_d = scnt_n;
        end
        if (sw_kill) begin
          active_d[0] = 1'b0;
        end
      end
      if (!sw_kill) begin
        case (ch)
          2'd2:    timer_d[2] = tcur - 24'sd64;
          2'd3:    timer_d[3] = tcur - 24'sd16;
          default: timer_d[ch] = tcur - 24'sd4;
        endcase
      end
    end

    if (cmd_i.step) begin
      timer_d[ch] = tcur + $signed(add_amt);
      if (ch == 2'd2) begin
        pos_d = pos_q + 6'd1;
      end
      if (ch == 2'd3) begin
        noise_d = lfsr_n;
      end
    end

    if (cmd_i.sign) begin
      sign_d   = (ch == 2'd3) ? !noise_q[15] : (tcur < $signed({12'd0, duty_val}));
      rvalid_d = wvalid_q[raddr];
      if (frame_q[6:0] == 7'd0 && freq_q[ch][14] && len_full != 16'd0) begin
        duty_d[ch] = (duty_q[ch] & ~lmask) | (len_n & lmask);
        if ((len_n & lmask) == 16'd0) begin
          active_d[ch] = 1'b0;
        end
      end
      if (ch != 2'd2 && frame_q == ENV_STEP) begin
        if (!ecnt_n[3] && ecnt_n != 4'sd0) begin
          ecnt_d[ek] = ecnt_n;
        end else begin
          if (ecnt_n == 4'sd0) begin
            if (ereg[11] && lvl_q[ek] != 4'd15) begin
              lvl_d[ek] = lvl_q[ek] + 4'd1;
            end else if (!ereg[11] && lvl_q[ek] != 4'd0) begin
              lvl_d[ek] = lvl_q[ek] - 4'd1;
            end
          end else begin
            lvl_d[ek] = ereg[15:12];
          end
          ecnt_d[ek] = $signed({1'b0, ereg[10:8]});
        end
      end
    end

    if (cmd_i.level) begin
      if (ch == 2'd2) begin
        data_d[2] = $signed({1'b0, wave_level(nib_s)});
      end else begin
        data_d[ch] = sign_q ? -$signed({2'd0, mag8}) : $signed({2'd0, mag8});
      end
    end

    if (cmd_i.mul) begin
      prod_l_d = mix_levels_q[12 + ch] ? 14'(ds * $signed({1'b0, mix_levels_q[6:4]})) : '0;
      prod_r_d = mix_levels_q[8 + ch]  ? 14'(ds * $signed({1'b0, mix_levels_q[2:0]})) : '0;
    end

    if (cmd_i.acc) begin
      acc_l_d = prod_l_q[13] ? acc_l_q - $signed({5'd0, q_l[22:14]})
                             : acc_l_q + $signed({5'd0, q_l[22:14]});
      acc_r_d = prod_r_q[13] ? acc_r_q - $signed({5'd0, q_r[22:14]})
                             : acc_r_q + $signed({5'd0, q_r[22:14]});
    end

    if (cmd_i.direct) begin
      acc_l_d = acc_l_q + (mix_control_q[9]  ? a_add : 14'sd0)
                        + (mix_control_q[13] ? b_add : 14'sd0);
      acc_r_d = acc_r_q + (mix_control_q[8]  ? a_add : 14'sd0)
                        + (mix_control_q[12] ? b_add : 14'sd0);
      frame_d = frame_q + 9'd1;
    end

    if (cmd_i.load) begin
      left_d      = {~c_l[9], c_l[8:0], 5'd0};
      right_d     = {~c_r[9], c_r[8:0], 5'd0};
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= reg_kind_i;
      wch_q   <= channel_i;
      widx_q  <= wave_index_i;
      wmask_q <= write_mask_i;
      wdata_q <= write_data_i;
      da_q    <= direct_a_i;
      db_q    <= direct_b_i;
    end
    data_q   <= data_d;
    sign_q   <= sign_d;
    rvalid_q <= rvalid_d;
    prod_l_q <= prod_l_d;
    prod_r_q <= prod_r_d;
    acc_l_q  <= acc_l_d;
    acc_r_q  <= acc_r_d;
    left_q   <= left_d;
    right_q  <= right_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_levels_q  <= '0;
      mix_control_q <= '0;
      bias_q        <= BIAS_RESET;
      for (int i = 0; i < 4; i++) begin
        duty_q[i]  <= '0;
        freq_q[i]  <= '0;
        timer_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        lvl_q[i]  <= '0;
        ecnt_q[i] <= '0;
      end
      sweep_q[0]  <= '0;
      sweep_q[1]  <= '0;
      on_q        <= 1'b0;
      active_q    <= '0;
      frame_q     <= '0;
      scount_q    <= '0;
      pos_q       <= '0;
      noise_q     <= '0;
      wvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIX_LEVELS:  mix_levels_q  <= cfg_data_i;
          CFG_MIX_CONTROL: mix_control_q <= cfg_data_i;
          CFG_BIAS:        bias_q        <= cfg_data_i[9:0];
          default: begin
          end
        endcase
      end
      sweep_q     <= sweep_d;
      duty_q      <= duty_d;
      freq_q      <= freq_d;
      timer_q     <= timer_d;
      lvl_q       <= lvl_d;
      ecnt_q      <= ecnt_d;
      on_q        <= on_d;
      active_q    <= active_d;
      frame_q     <= frame_d;
      scount_q    <= scount_d;
      pos_q       <= pos_d;
      noise_q     <= noise_d;
      wvalid_q    <= wvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.powered    = on_q;
  assign stat_o.runs       = runs;
  assign stat_o.sweep_kill = sw_kill;
  assign stat_o.timer_le0  = le0;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;

endmodule

// ===== design/psg_chk.sv =====
`include "psg_four_channel_sound_generator_defines.svh"

module psg_chk import psg_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_USER_W-1:0]  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic s_hs;
  logic m_stall;

  assign s_hs    = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  // one request in flight at a time
  `PSG_ASSERT_NEXT(a_busy_after_request, s_hs, !s_axis_tready, "ready right after a request")
  // no sample appears on the cycle after a request is taken
  `PSG_ASSERT_NEXT(a_no_early_sample, s_hs, !$rose(m_axis_tvalid), "sample too early")
  // a write request never yields a sample while it is taken
  `PSG_ASSERT_SAME(a_write_idle_out, s_hs && s_axis_tuser[0] && !m_axis_tvalid,
                   !$rose(m_axis_tvalid), "write request produced a sample")
  `PSG_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid, "sample dropped while stalled")
  `PSG_ASSERT_NEXT(a_out_stable, m_stall, $stable(m_axis_tdata), "sample changed while stalled")

endmodule

bind psg_four_channel_sound_generator psg_chk u_psg_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/psg_four_channel_sound_generator_test.sv =====
`timescale 1ns / 100ps

module psg_four_channel_sound_generator_test;
  import psg_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // channel, wave_index, write_mask, write_data, direct_a, direct_b, zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // opcode, reg_kind
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // left_sample, right_sample, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [1:0]            cfg_idx_i;
  logic [15:0]           cfg_data_i;

  localparam bit OP_TICK  = 1'b0;
  localparam bit OP_WRITE = 1'b1;

  typedef struct {
    logic [14:0] left;
    logic [14:0] right;
  } stereo_t;

  stereo_t     sample_q[$];
  int          errors;
  int          ticks_sent;
  int          writes_sent;
  int          samples_seen;
  bit          no_idle;
  bit          hold_rx;

  // predictor state
  logic [7:0]  sweep_r[2];
  logic [15:0] duty_r[4];
  logic [15:0] freq_r[4];
  logic [7:0]  status_r;
  int          frame_pos;
  int          sweep_cnt;
  int          timer[4];
  int          env_lvl[3];
  int          env_cnt[3];
  int          wave_pos;
  logic [15:0] lfsr;
  logic [7:0]  wave_ram[32];
  logic [15:0] levels_cfg;
  logic [15:0] control_cfg;
  logic [9:0]  bias_cfg;

  psg_four_channel_sound_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int noise_len();
    int d;
    d = int'(freq_r[3][2:0]) * 16;
    if (d == 0) d = 8;
    return d << freq_r[3][7:4];
  endfunction

  function automatic void length_tick(int ch, logic [15:0] lmask);
    logic [15:0] n;
    if (frame_pos % 128 == 0 && freq_r[ch][14] && (duty_r[ch] & lmask) != 0) begin
      n = (duty_r[ch] & lmask) - 16'd1;
      duty_r[ch] = (duty_r[ch] & ~lmask) | n;
      if (n == 0) status_r[ch] = 1'b0;
    end
  endfunction

  function automatic void envelope_tick(int k, logic [15:0] r);
    if (frame_pos != 448) return;
    env_cnt[k]--;
    if (env_cnt[k] > 0) return;
    if (env_cnt[k] == 0) begin
      if (r[11] && env_lvl[k] < 15) env_lvl[k]++;
      else if (!r[11] && env_lvl[k] > 0) env_lvl[k]--;
    end else begin
      env_lvl[k] = r[15:12];
    end
    env_cnt[k] = r[10:8];
  endfunction

  function automatic void apply_write(logic [2:0] kind, logic [1:0] ch, logic [3:0] widx,
                                      logic [15:0] mask, logic [15:0] val);
    logic [7:0] m8;
    int bank;
    bit on;
    on = status_r[7];
    case (kind)
      KIND_SWEEP: if (on) begin
        m8 = (ch == 0) ? 8'h7F : 8'hE0;
        sweep_r[ch[1]] = (sweep_r[ch[1]] & ~m8) | (val[7:0] & m8);
      end
      KIND_DUTY: if (on) begin
        if (ch == 2) mask &= 16'hE0FF;
        if (ch == 3) mask &= 16'hFF3F;
        duty_r[ch] = (duty_r[ch] & ~mask) | (val & mask);
      end
      KIND_FREQ: if (on) begin
        mask &= (ch == 3) ? 16'h40FF : 16'h47FF;
        freq_r[ch] = (freq_r[ch] & ~mask) | (val & mask);
        // trigger bit acts even when masked off
        if (val[15]) begin
          if (ch < 2) begin
            if (ch == 0) sweep_cnt = sweep_r[0][6:4];
            env_lvl[ch] = duty_r[ch][15:12];
            env_cnt[ch] = duty_r[ch][10:8];
            timer[ch] = 2048 - int'(freq_r[ch][10:0]);
          end else if (ch == 2) begin
            wave_pos = 0;
            timer[2] = 2048 - int'(freq_r[2][10:0]);
          end else begin
            lfsr = freq_r[3][3] ? 16'h0040 : 16'h4000;
            env_lvl[2] = duty_r[3][15:12];
            env_cnt[2] = duty_r[3][10:8];
            timer[3] = noise_len();
          end
          status_r[ch] = 1'b1;
        end
      end
      KIND_MASTER: begin
        status_r[7] = val[7];
        if (!val[7]) begin
          sweep_r[0] = '0;
          sweep_r[1] = '0;
          for (int i = 0; i < 4; i++) begin
            duty_r[i] = '0;
            freq_r[i] = '0;
          end
          status_r[3:0] = '0;
          frame_pos = 0;
        end
      end
      KIND_WAVE: begin
        bank = sweep_r[1][6] ? 0 : 1;
        wave_ram[bank * 16 + widx] = val[7:0];
      end
      default: ;
    endcase
  endfunction

  function automatic stereo_t mix_tick(logic [7:0] da, logic [7:0] db);
    int data[4];
    int left, right, a, b, per, duty, bank, sh;
    logic [7:0] byte_v;
    stereo_t s;
    data = '{0, 0, 0, 0};
    left = 0;
    right = 0;
    a = int'($signed(da));
    b = int'($signed(db));
    if (status_r[7]) begin
      for (int i = 0; i < 2; i++) begin
        if (!status_r[i]) continue;
        if (i == 0 && frame_pos % 256 == 128 && sweep_r[0][6:4] != 0) begin
          sweep_cnt--;
          if (sweep_cnt <= 0) begin
            int f, d;
            f = freq_r[0][10:0];
            d = f >> sweep_r[0][2:0];
            f = sweep_r[0][3] ? f - d : f + d;
            if (f < 'h800) begin
              freq_r[0][10:0] = f[10:0];
              sweep_cnt = sweep_r[0][6:4];
            end else begin
              // frequency overflow kills the channel from this tick on
              status_r[0] = 1'b0;
              continue;
            end
          end
        end
        per = 2048 - int'(freq_r[i][10:0]);
        timer[i] -= 4;
        while (timer[i] <= 0) timer[i] += per;
        case (duty_r[i][7:6])
          2'd0: duty = per * 7 / 8;
          2'd1: duty = per * 6 / 8;
          2'd2: duty = per * 4 / 8;
          default: duty = per * 2 / 8;
        endcase
        data[i] = (timer[i] < duty) ? -128 : 128;
        length_tick(i, 16'h003F);
        envelope_tick(i, duty_r[i]);
        data[i] = data[i] * env_lvl[i] / 15;
      end
      if (status_r[2] && sweep_r[1][7]) begin
        per = 2048 - int'(freq_r[2][10:0]);
        timer[2] -= 64;
        while (timer[2] <= 0) begin
          timer[2] += per;
          wave_pos = (wave_pos + 1) & 63;
        end
        bank = sweep_r[1][6];
        if (sweep_r[1][5] && wave_pos >= 32) bank ^= 1;
        byte_v = wave_ram[bank * 16 + ((wave_pos & 31) >> 1)];
        data[2] = (wave_pos & 1) ? byte_v[3:0] : byte_v[7:4];
        length_tick(2, 16'h00FF);
        sh = duty_r[2][15:13];
        if (sh == 0) data[2] >>= 4;
        else if (sh == 2) data[2] >>= 1;
        else if (sh == 3) data[2] >>= 2;
        else if (sh >= 4) data[2] = data[2] * 3 / 4;
        data[2] = data[2] * 256 / 15;
      end
      if (status_r[3]) begin
        timer[3] -= 16;
        while (timer[3] <= 0) begin
          timer[3] += noise_len();
          lfsr[15] = 1'b0;
          if (lfsr[0])
            lfsr = 16'h8000 | ((lfsr >> 1) ^ (freq_r[3][3] ? 16'h0060 : 16'h6000));
          else
            lfsr >>= 1;
        end
        data[3] = lfsr[15] ? 128 : -128;
        length_tick(3, 16'h003F);
        envelope_tick(2, duty_r[3]);
        data[3] = data[3] * env_lvl[2] / 15;
      end
      for (int i = 0; i < 4; i++) begin
        if (control_cfg[1:0] == 0) data[i] = data[i] >>> 2;
        else if (control_cfg[1:0] == 1) data[i] = data[i] >>> 1;
        if (levels_cfg[12 + i]) left += data[i] * int'(levels_cfg[6:4]) / 7;
        if (levels_cfg[8 + i]) right += data[i] * int'(levels_cfg[2:0]) / 7;
      end
      if (control_cfg[9])  left  += a * (control_cfg[2] ? 4 : 2);
      if (control_cfg[8])  right += a * (control_cfg[2] ? 4 : 2);
      if (control_cfg[13]) left  += b * (control_cfg[3] ? 4 : 2);
      if (control_cfg[12]) right += b * (control_cfg[3] ? 4 : 2);
      frame_pos = (frame_pos + 1) & 511;
    end
    left += int'(bias_cfg);
    right += int'(bias_cfg);
    if (left < 0) left = 0;
    if (left > 'h3FF) left = 'h3FF;
    if (right < 0) right = 0;
    if (right > 'h3FF) right = 'h3FF;
    left = (left - 'h200) * 32;
    right = (right - 'h200) * 32;
    s.left = left[14:0];
    s.right = right[14:0];
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [14:0] got, logic [14:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  task automatic send_request(bit op, logic [2:0] kind, logic [1:0] ch, logic [3:0] widx,
                              logic [15:0] mask, logic [15:0] val,
                              logic [7:0] da, logic [7:0] db);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {kind, op};
    s_axis_tdata  <= {2'b00, db, da, val, mask, widx, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_TICK) begin
      sample_q.push_back(mix_tick(da, db));
      ticks_sent++;
    end else begin
      apply_write(kind, ch, widx, mask, val);
      writes_sent++;
    end
  endtask

  task automatic send_tick();
    send_request(OP_TICK, 3'($urandom), 2'($urandom), 4'($urandom), 16'($urandom),
                 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_write(logic [2:0] kind, logic [1:0] ch, logic [3:0] widx,
                            logic [15:0] mask, logic [15:0] val);
    send_request(OP_WRITE, kind, ch, widx, mask, val, 8'($urandom), 8'($urandom));
  endtask

  // mixer registers only change once the block has drained
  task automatic set_mixer(logic [15:0] lv, logic [15:0] ctl, logic [9:0] bias);
    s_axis_tvalid <= 1'b0;
    wait (sample_q.size() == 0);
    repeat (150) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MIX_LEVELS;
    cfg_data_i <= lv;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MIX_CONTROL;
    cfg_data_i <= ctl;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BIAS;
    cfg_data_i <= {6'd0, bias};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    levels_cfg  = lv;
    control_cfg = ctl;
    bias_cfg    = bias;
  endtask

  task automatic test_directed();
    send_request(OP_TICK, KIND_SWEEP, 2'd0, 4'd0, 16'h0000, 16'h0000, 8'h80, 8'h7F);
    send_write(KIND_DUTY, 2'd1, 4'd0, 16'hFFFF, 16'hFFFF);   // ignored while off
    send_write(KIND_WAVE, 2'd0, 4'd0, 16'h0000, 16'h00FF);   // works while off
    send_write(KIND_WAVE, 2'd3, 4'd15, 16'hFFFF, 16'hFF10);
    send_write(KIND_MASTER, 2'd0, 4'd0, 16'h0000, 16'h0080);
    send_write(KIND_SWEEP, 2'd2, 4'd0, 16'h0000, 16'h00E0);
    send_write(KIND_WAVE, 2'd0, 4'd1, 16'h0000, 16'h009A);   // other bank now
    send_write(KIND_SWEEP, 2'd0, 4'd0, 16'h0000, 16'h0011);
    for (int c = 0; c < 4; c++) begin
      send_write(KIND_DUTY, 2'(c), 4'd0, 16'hFFFF, 16'hF7C1);
      send_write(KIND_FREQ, 2'(c), 4'd0, 16'hFFFF, c == 0 ? 16'hC7F0 : 16'hC008);
    end
    send_write(3'd5, 2'd0, 4'd0, 16'hFFFF, 16'hFFFF);
    send_write(3'd7, 2'd3, 4'd0, 16'hFFFF, 16'h0000);
    send_request(OP_TICK, KIND_SWEEP, 2'd0, 4'd0, 16'h0, 16'h0, 8'h7F, 8'h80);
    send_request(OP_TICK, KIND_SWEEP, 2'd0, 4'd0, 16'h0, 16'h0, 8'h00, 8'hFF);
    send_write(KIND_FREQ, 2'd2, 4'd0, 16'h0000, 16'h8000);   // trigger with mask off
    send_write(KIND_MASTER, 2'd0, 4'd0, 16'hFFFF, 16'hFF7F); // power down
    send_tick();
    send_write(KIND_MASTER, 2'd0, 4'd0, 16'h0000, 16'h0080);
    send_tick();
  endtask

  // maybe power up, program some channels with random content, then ticks with occasional writes
  task automatic song_phrase(int nticks);
    if ($urandom_range(0, 5) == 0) send_write(KIND_MASTER, 2'd0, 4'd0, 16'($urandom), 16'h0080);
    send_write(KIND_SWEEP, 2'd0, 4'd0, 16'($urandom), 16'($urandom));
    send_write(KIND_SWEEP, 2'($urandom_range(1, 3)), 4'd0, 16'($urandom),
               16'($urandom) | 16'h0080);
    for (int c = 0; c < 4; c++) begin
      if ($urandom_range(0, 3) != 0) begin
        send_write(KIND_DUTY, 2'(c), 4'd0, 16'($urandom), 16'($urandom));
        send_write(KIND_FREQ, 2'(c), 4'd0, 16'($urandom), 16'($urandom) | 16'h8000);
      end
    end
    repeat ($urandom_range(0, 4))
      send_write(KIND_WAVE, 2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
    for (int i = 0; i < nticks; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_write(3'($urandom), 2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
      else
        send_tick();
    end
  endtask

  task automatic test_random(int nitems);
    int start;
    start = ticks_sent + writes_sent;
    while (ticks_sent + writes_sent - start < nitems)
      song_phrase($urandom_range(0, 7) == 0 ? 300 : $urandom_range(5, 60));
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    repeat (30) send_tick();
  endtask

  always @(posedge clk_i) begin
    stereo_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      samples_seen++;
      if (sample_q.size() == 0) begin
        errors++;
        $display("unexpected sample %h at %0t", m_axis_tdata, $time);
      end else begin
        want = sample_q.pop_front();
        if (m_axis_tdata[14:0] !== want.left)
          report_mismatch("left", m_axis_tdata[14:0], want.left);
        if (m_axis_tdata[29:15] !== want.right)
          report_mismatch("right", m_axis_tdata[29:15], want.right);
      end
    end
  end

  // receiver stalls; the long hold-off for test_backpressure is made here
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_rx = 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #1000000;
    $display("timeout");
    $display("psg_four_channel_sound_generator_test NOT OK");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    errors = 0;
    ticks_sent = 0;
    writes_sent = 0;
    samples_seen = 0;
    no_idle = 1'b0;
    hold_rx = 1'b0;
    sweep_r = '{8'd0, 8'd0};
    for (int i = 0; i < 4; i++) begin
      duty_r[i] = '0;
      freq_r[i] = '0;
      timer[i] = 0;
    end
    for (int i = 0; i < 3; i++) begin
      env_lvl[i] = 0;
      env_cnt[i] = 0;
    end
    for (int i = 0; i < 32; i++) wave_ram[i] = '0;
    status_r = '0;
    frame_pos = 0;
    sweep_cnt = 0;
    wave_pos = 0;
    lfsr = '0;
    levels_cfg = '0;
    control_cfg = '0;
    bias_cfg = BIAS_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_mixer(16'hFFFF, 16'hFFFF, 10'd0);
    test_random(200);
    test_backpressure();
    set_mixer(16'h0000, 16'h0000, 10'h3FF);
    test_random(100);
    set_mixer(16'($urandom), 16'($urandom), 10'($urandom));
    test_random(200);
    set_mixer(16'hF3F3, 16'h3302, 10'd512);
    test_random(150);
    no_idle = 1'b1;
    set_mixer(16'($urandom), 16'($urandom), 10'($urandom));
    test_random(150);
    s_axis_tvalid <= 1'b0;
    wait (sample_q.size() == 0);
    repeat (200) @(posedge clk_i);

    $display("sent %0d ticks and %0d register writes, checked %0d samples",
             ticks_sent, writes_sent, samples_seen);
    $display("covered power gating, triggers, sweep, length, envelopes, wave banks, noise");
    if (errors == 0 && sample_q.size() == 0) begin
      $display("psg_four_channel_sound_generator_test OK");
    end else begin
      $display("psg_four_channel_sound_generator_test NOT OK");
    end
    $finish;
  end

endmodule
